FILE: sv/lspb_pkg.sv
// Shared types and constants for the LSPB trajectory sampler.
// Used by lspb_setup and lspb_trajectory_sample; depends on nothing.
`default_nettype none

package lspb_pkg;

    localparam int DATA_W    = 32;
    localparam int TIME_W    = 31;
    localparam int IDX_W     = 16;
    localparam int ADDR_W    = 5;
    localparam int DIV_W     = 50;
    localparam int DIV_CNT_W = 6;

    localparam logic [TIME_W-1:0] TF_RESET = 31'd655360;
    localparam logic [TIME_W-1:0] TS_RESET = 31'd66;

    // Register map, word addressed through paddr[4:2]
    typedef enum logic [2:0] {
        REG_Q0 = 3'd0,
        REG_QF = 3'd1,
        REG_TF = 3'd2,
        REG_V  = 3'd3,
        REG_TS = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEG_ACCEL  = 2'd0,
        SEG_CRUISE = 2'd1,
        SEG_DECEL  = 2'd2
    } seg_t;

    typedef enum logic [2:0] {
        CAL_IDLE,
        CAL_MUL,
        CAL_CHK,
        CAL_TB,
        CAL_SET_TB,
        CAL_ACC,
        CAL_SET_ACC
    } cal_state_t;

    // Profile terms derived from the registers, constant between writes
    typedef struct packed {
        logic              busy;
        logic              err;
        logic [TIME_W-1:0] tb;
        logic [TIME_W-1:0] tf_m_tb;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] acc_mag;
        logic              acc_neg;
        logic [DATA_W-1:0] neg_acc;
        logic [DATA_W:0]   qsum;
    } setup_t;

endpackage

`default_nettype wire

FILE: sv/lspb_setup.sv
// Profile setup: feasibility check, blend time and blend acceleration.
// One shared restoring divider, run twice after each register write; uses lspb_pkg.
`default_nettype none

module lspb_setup
    import lspb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr,
    input  logic signed [DATA_W-1:0] q0,
    input  logic signed [DATA_W-1:0] qf,
    input  logic signed [DATA_W-1:0] v,
    input  logic [TIME_W-1:0]        tf,
    output setup_t                   setup
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    cal_state_t state_reg, state_next;

    logic do_mul, do_chk, do_step, do_set_tb, do_set_acc, busy;

    logic signed [63:0]     vt_reg;
    logic signed [DATA_W:0] d_reg;
    logic [DATA_W-1:0]      rem_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [DATA_W-1:0]      dsr_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic              err_reg;
    logic [TIME_W-1:0] tb_reg, tf_m_tb_reg;
    logic [DATA_W-1:0] acc_reg, acc_mag_reg, neg_acc_reg;
    logic              acc_neg_reg;
    logic [DATA_W:0]   qsum_reg;

    // Combinational terms
    logic signed [63:0] b1, b2, lo, hi, diff;
    logic [63:0]        diff_mag;
    logic [DATA_W-1:0]  vmag;
    logic               vneg;
    logic [DATA_W:0]    shifted;
    logic [DATA_W+1:0]  trial;
    logic               fits;
    logic [TIME_W-1:0]  tb_val;
    logic [DATA_W-1:0]  acc_mag_val, acc_val;

    assign vneg = v[DATA_W-1];
    assign vmag = vneg ? (32'd0 - v) : v;

    assign b1   = {{15{d_reg[DATA_W]}}, d_reg, 16'd0};
    assign b2   = {{14{d_reg[DATA_W]}}, d_reg, 17'd0};
    assign lo   = (b1 < b2) ? b1 : b2;
    assign hi   = (b1 < b2) ? b2 : b1;
    assign diff = vt_reg - b1;
    assign diff_mag = diff[63] ? (64'd0 - diff) : diff;

    // One quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = !trial[DATA_W+1];

    assign tb_val = (v == '0) ? 31'd1 : quo_reg[TIME_W-1:0];

    always_comb
    begin
        if (tb_reg == '0)
        begin
            acc_mag_val = vneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (vneg)
        begin
            acc_mag_val = (quo_reg > 50'h0_0000_8000_0000) ? 32'h8000_0000
                                                           : quo_reg[DATA_W-1:0];
        end
        else
        begin
            acc_mag_val = (quo_reg > 50'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                           : quo_reg[DATA_W-1:0];
        end
        acc_val = vneg ? (32'd0 - acc_mag_val) : acc_mag_val;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CAL_IDLE:    state_next = CAL_IDLE;
            CAL_MUL:     state_next = CAL_CHK;
            CAL_CHK:     state_next = CAL_TB;
            CAL_TB:      state_next = (cnt_reg == DIV_LAST) ? CAL_SET_TB : CAL_TB;
            CAL_SET_TB:  state_next = CAL_ACC;
            CAL_ACC:     state_next = (cnt_reg == DIV_LAST) ? CAL_SET_ACC : CAL_ACC;
            CAL_SET_ACC: state_next = CAL_IDLE;
            default:     state_next = CAL_IDLE;
        endcase
        if (cfg_wr)
        begin
            state_next = CAL_MUL;
        end
    end

    // Outputs of the sequencer
    always_comb
    begin
        do_mul     = 1'b0;
        do_chk     = 1'b0;
        do_step    = 1'b0;
        do_set_tb  = 1'b0;
        do_set_acc = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            CAL_IDLE:    busy       = 1'b0;
            CAL_MUL:     do_mul     = 1'b1;
            CAL_CHK:     do_chk     = 1'b1;
            CAL_TB:      do_step    = 1'b1;
            CAL_SET_TB:  do_set_tb  = 1'b1;
            CAL_ACC:     do_step    = 1'b1;
            CAL_SET_ACC: do_set_acc = 1'b1;
            default:     busy       = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CAL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Work registers of the multiply and divide steps
    always_ff @(posedge clk)
    begin
        if (do_mul)
        begin
            vt_reg <= v * $signed({1'b0, tf});
            d_reg  <= $signed({qf[DATA_W-1], qf}) - $signed({q0[DATA_W-1], q0});
        end
        if (do_chk)
        begin
            rem_reg <= '0;
            quo_reg <= diff_mag[DIV_W-1:0];
            dsr_reg <= vmag;
            cnt_reg <= '0;
        end
        else if (do_set_tb)
        begin
            rem_reg <= '0;
            quo_reg <= {2'b00, vmag, 16'd0};
            dsr_reg <= {1'b0, tb_val};
            cnt_reg <= '0;
        end
        else if (do_step)
        begin
            rem_reg <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Results; reset values match the register reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg     <= 1'b0;
            tb_reg      <= 31'd1;
            tf_m_tb_reg <= TF_RESET - 31'd1;
            acc_reg     <= '0;
            acc_mag_reg <= '0;
            acc_neg_reg <= 1'b0;
            neg_acc_reg <= '0;
            qsum_reg    <= '0;
        end
        else
        begin
            if (do_mul)
            begin
                qsum_reg <= {q0[DATA_W-1], q0} + {qf[DATA_W-1], qf};
            end
            if (do_chk)
            begin
                err_reg <= (tf == '0) || (vt_reg < lo) || (vt_reg > hi);
            end
            if (do_set_tb)
            begin
                tb_reg      <= tb_val;
                tf_m_tb_reg <= tf - tb_val;
            end
            if (do_set_acc)
            begin
                acc_reg     <= acc_val;
                acc_mag_reg <= acc_mag_val;
                acc_neg_reg <= vneg;
                neg_acc_reg <= (acc_val == 32'h8000_0000) ? 32'h7FFF_FFFF
                                                          : (32'd0 - acc_val);
            end
        end
    end

    assign setup.busy    = busy;
    assign setup.err     = err_reg;
    assign setup.tb      = tb_reg;
    assign setup.tf_m_tb = tf_m_tb_reg;
    assign setup.acc     = acc_reg;
    assign setup.acc_mag = acc_mag_reg;
    assign setup.acc_neg = acc_neg_reg;
    assign setup.neg_acc = neg_acc_reg;
    assign setup.qsum    = qsum_reg;

endmodule

`default_nettype wire

FILE: sv/lspb_trajectory_sample.sv
// LSPB (trapezoidal velocity) trajectory sampler: register file, 8-stage sample pipeline.
// Depends on lspb_pkg and lspb_setup.
`default_nettype none

// Each request carries a sample index; the block returns position, velocity, acceleration
// in signed Q16.16, plus segment code, last-sample mark and a speed error flag. The pipeline
// has eight register stages and takes one request per clock unless the setup block is busy or
// the full pipeline is held by out_ready. After any register write the blend time and
// acceleration are recomputed by a shared one-bit-per-cycle divider: in_ready stays low
// after the write while the two 50-step divisions run.
module lspb_trajectory_sample
    import lspb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [IDX_W-1:0]         sample_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] position,
    output logic signed [DATA_W-1:0] velocity,
    output logic signed [DATA_W-1:0] acceleration,
    output logic [1:0]               segment,
    output logic                     is_last,
    output logic                     speed_error
);

    // Register file
    logic signed [DATA_W-1:0] q0_reg, qf_reg, v_reg;
    logic [TIME_W-1:0]        tf_reg, ts_reg;
    logic                     cfg_wr;
    cfg_reg_t                 cfg_idx;
    setup_t                   setup;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_reg <= '0;
            qf_reg <= '0;
            tf_reg <= TF_RESET;
            v_reg  <= '0;
            ts_reg <= TS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_Q0:  q0_reg <= pwdata;
                REG_QF:  qf_reg <= pwdata;
                REG_TF:  tf_reg <= pwdata[TIME_W-1:0];
                REG_V:   v_reg  <= pwdata;
                REG_TS:  ts_reg <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_Q0:  prdata = q0_reg;
            REG_QF:  prdata = qf_reg;
            REG_TF:  prdata = {1'b0, tf_reg};
            REG_V:   prdata = v_reg;
            REG_TS:  prdata = {1'b0, ts_reg};
            default: prdata = '0;
        endcase
    end

    lspb_setup u_setup (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .q0     (q0_reg),
        .qf     (qf_reg),
        .v      (v_reg),
        .tf     (tf_reg),
        .setup  (setup)
    );

    // Stage valids and per-stage enables: a stage loads when it is empty or drains
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic e1, e2, e3, e4, e5, e6, e7, e8;

    assign e8 = !v8_reg || out_ready;
    assign e7 = !v7_reg || e8;
    assign e6 = !v6_reg || e7;
    assign e5 = !v5_reg || e6;
    assign e4 = !v4_reg || e5;
    assign e3 = !v3_reg || e4;
    assign e2 = !v2_reg || e3;
    assign e1 = !v1_reg || e2;

    assign in_ready  = e1 && !setup.busy;
    assign out_valid = v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (e1) v1_reg <= in_valid && !setup.busy;
            if (e2) v2_reg <= v1_reg;
            if (e3) v3_reg <= v2_reg;
            if (e4) v4_reg <= v3_reg;
            if (e5) v5_reg <= v4_reg;
            if (e6) v6_reg <= v5_reg;
            if (e7) v7_reg <= v6_reg;
            if (e8) v8_reg <= v7_reg;
        end
    end

    // Stage 1: sample time and next sample time
    logic [46:0] t1_reg;
    logic [47:0] tn1_reg;
    logic [16:0] idx_p1;

    assign idx_p1 = {1'b0, sample_index} + 17'd1;

    always_ff @(posedge clk)
    begin
        if (e1)
        begin
            t1_reg  <= {31'd0, sample_index} * {16'd0, ts_reg};
            tn1_reg <= {31'd0, idx_p1} * {17'd0, ts_reg};
        end
    end

    // Stage 2: segment select, time argument of the blend
    logic               is_acc, is_cru;
    logic signed [48:0] udiff;
    logic [47:0]        wmag2_next;
    seg_t               seg2_reg;
    logic               last2_reg;
    logic [47:0]        wmag2_reg;
    logic               wneg2_reg;
    logic signed [32:0] cd2_reg;

    assign is_acc = t1_reg <= {16'd0, setup.tb};
    assign is_cru = t1_reg <= {16'd0, setup.tf_m_tb};
    assign udiff  = $signed({18'd0, tf_reg}) - $signed({2'b00, t1_reg});
    assign wmag2_next = is_acc   ? {1'b0, t1_reg} :
                        udiff[48] ? 48'(49'd0 - udiff) : udiff[47:0];

    always_ff @(posedge clk)
    begin
        if (e2)
        begin
            seg2_reg  <= is_acc ? SEG_ACCEL : (is_cru ? SEG_CRUISE : SEG_DECEL);
            last2_reg <= tn1_reg >= {17'd0, tf_reg};
            wmag2_reg <= wmag2_next;
            wneg2_reg <= !is_acc && udiff[48];
            cd2_reg   <= {t1_reg[31:0], 1'b0} - {2'b00, tf_reg};
        end
    end

    // Stage 3: velocity partial products, cruise product
    logic [55:0]        pplo3_reg, pphi3_reg;
    logic               neg3_reg;
    logic signed [63:0] p3_reg;
    logic signed [64:0] p3_full;
    seg_t               seg3_reg;
    logic               last3_reg;
    logic [47:0]        wmag3_reg;
    logic               wneg3_reg;

    assign p3_full = v_reg * cd2_reg;

    always_ff @(posedge clk)
    begin
        if (e3)
        begin
            pplo3_reg <= {24'd0, setup.acc_mag} * {32'd0, wmag2_reg[23:0]};
            pphi3_reg <= {24'd0, setup.acc_mag} * {32'd0, wmag2_reg[47:24]};
            neg3_reg  <= setup.acc_neg ^ wneg2_reg;
            p3_reg    <= p3_full[63:0];
            seg3_reg  <= seg2_reg;
            last3_reg <= last2_reg;
            wmag3_reg <= wmag2_reg;
            wneg3_reg <= wneg2_reg;
        end
    end

    // Stage 4: sum partials, cruise numerator
    logic [79:0]        prod4_reg;
    logic signed [63:0] num4_reg;
    logic               neg4_reg;
    seg_t               seg4_reg;
    logic               last4_reg;
    logic [47:0]        wmag4_reg;
    logic               wneg4_reg;

    always_ff @(posedge clk)
    begin
        if (e4)
        begin
            prod4_reg <= {24'd0, pplo3_reg} + {pphi3_reg, 24'd0};
            num4_reg  <= $signed({{15{setup.qsum[DATA_W]}}, setup.qsum, 16'd0}) + p3_reg;
            neg4_reg  <= neg3_reg;
            seg4_reg  <= seg3_reg;
            last4_reg <= last3_reg;
            wmag4_reg <= wmag3_reg;
            wneg4_reg <= wneg3_reg;
        end
    end

    // Stage 5: saturate velocity, cruise position
    logic [63:0]        m5;
    logic [DATA_W-1:0]  velmag5;
    logic signed [63:0] numb5;
    logic [46:0]        q5;
    logic [DATA_W-1:0]  pos1_5;
    logic [DATA_W-1:0]  velmag5_reg, vel5_reg, pos1_5_reg;
    logic               velneg5_reg;
    seg_t               seg5_reg;
    logic               last5_reg;
    logic [47:0]        wmag5_reg;
    logic               wneg5_reg;

    assign m5 = prod4_reg[79:16];

    always_comb
    begin
        if (neg4_reg)
        begin
            velmag5 = (m5 > 64'h8000_0000) ? 32'h8000_0000 : m5[DATA_W-1:0];
        end
        else
        begin
            velmag5 = (m5 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m5[DATA_W-1:0];
        end
        // Round toward zero before the shift
        numb5 = num4_reg + (num4_reg[63] ? 64'sd131071 : 64'sd0);
        q5    = numb5[63:17];
        if (q5[46:31] == {16{q5[31]}})
        begin
            pos1_5 = q5[DATA_W-1:0];
        end
        else
        begin
            pos1_5 = q5[46] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e5)
        begin
            velmag5_reg <= velmag5;
            vel5_reg    <= neg4_reg ? (32'd0 - velmag5) : velmag5;
            velneg5_reg <= neg4_reg;
            pos1_5_reg  <= pos1_5;
            seg5_reg    <= seg4_reg;
            last5_reg   <= last4_reg;
            wmag5_reg   <= wmag4_reg;
            wneg5_reg   <= wneg4_reg;
        end
    end

    // Stage 6: position partial products
    logic [55:0]       pplo6_reg, pphi6_reg;
    logic              neg6_reg;
    logic [DATA_W-1:0] vel6_reg, pos1_6_reg;
    seg_t              seg6_reg;
    logic              last6_reg;

    always_ff @(posedge clk)
    begin
        if (e6)
        begin
            pplo6_reg  <= {24'd0, velmag5_reg} * {32'd0, wmag5_reg[23:0]};
            pphi6_reg  <= {24'd0, velmag5_reg} * {32'd0, wmag5_reg[47:24]};
            neg6_reg   <= velneg5_reg ^ wneg5_reg;
            vel6_reg   <= vel5_reg;
            pos1_6_reg <= pos1_5_reg;
            seg6_reg   <= seg5_reg;
            last6_reg  <= last5_reg;
        end
    end

    // Stage 7: sum partials, scale and cap the position term
    logic [79:0]       prod7;
    logic [62:0]       m7;
    logic [34:0]       m7_reg;
    logic              eneg7_reg;
    logic [DATA_W-1:0] vel7_reg, pos1_7_reg;
    seg_t              seg7_reg;
    logic              last7_reg;

    assign prod7 = {24'd0, pplo6_reg} + {pphi6_reg, 24'd0};
    assign m7    = prod7[79:17];

    always_ff @(posedge clk)
    begin
        if (e7)
        begin
            m7_reg     <= (m7[62:34] != '0) ? 35'h4_0000_0000 : m7[34:0];
            eneg7_reg  <= neg6_reg ^ (seg6_reg == SEG_DECEL);
            vel7_reg   <= vel6_reg;
            pos1_7_reg <= pos1_6_reg;
            seg7_reg   <= seg6_reg;
            last7_reg  <= last6_reg;
        end
    end

    // Stage 8: blend position and the output register
    logic signed [36:0] base8, term8, sum8;
    logic [DATA_W-1:0]  posx8;
    logic [DATA_W-1:0]  pos_reg, vel_reg, acc_out_reg;
    logic [1:0]         seg_reg;
    logic               last_reg, err_reg;

    always_comb
    begin
        base8 = (seg7_reg == SEG_ACCEL) ? 37'(q0_reg) : 37'(qf_reg);
        term8 = eneg7_reg ? (37'd0 - {2'b00, m7_reg}) : {2'b00, m7_reg};
        sum8  = base8 + term8;
        if (sum8[36:31] == {6{sum8[31]}})
        begin
            posx8 = sum8[DATA_W-1:0];
        end
        else
        begin
            posx8 = sum8[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e8)
        begin
            err_reg <= setup.err;
            if (setup.err)
            begin
                pos_reg     <= '0;
                vel_reg     <= '0;
                acc_out_reg <= '0;
                seg_reg     <= SEG_ACCEL;
                last_reg    <= 1'b0;
            end
            else
            begin
                seg_reg  <= seg7_reg;
                last_reg <= last7_reg;
                case (seg7_reg)
                    SEG_ACCEL:
                    begin
                        pos_reg     <= posx8;
                        vel_reg     <= vel7_reg;
                        acc_out_reg <= setup.acc;
                    end
                    SEG_CRUISE:
                    begin
                        pos_reg     <= pos1_7_reg;
                        vel_reg     <= v_reg;
                        acc_out_reg <= '0;
                    end
                    default:
                    begin
                        pos_reg     <= posx8;
                        vel_reg     <= vel7_reg;
                        acc_out_reg <= setup.neg_acc;
                    end
                endcase
            end
        end
    end

    assign position     = pos_reg;
    assign velocity     = vel_reg;
    assign acceleration = acc_out_reg;
    assign segment      = seg_reg;
    assign is_last      = last_reg;
    assign speed_error  = err_reg;

    // A register write must hold off new requests while the divider runs
    a_wr_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ready)
        else $error("request accepted right after a register write");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speed_error |-> position == '0 && velocity == '0
            && acceleration == '0 && segment == SEG_ACCEL && !is_last)
        else $error("speed error result carries nonzero fields");

    a_cruise_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && segment == SEG_CRUISE |-> acceleration == '0 && velocity == v_reg)
        else $error("cruise result with wrong velocity or acceleration");

    a_seg_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment != 2'd3)
        else $error("undefined segment code at the output");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for lspb_trajectory_sample: directed table then random phases of APB setups.
// Expected samples come from a behavioral trajectory calculator below or from literal table rows; depends on lspb_pkg.
module tb;
    import lspb_pkg::*;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic [1:0]         seg;
        logic               last;
        logic               err;
    } sample_t;

    typedef struct {
        logic [15:0] idx;
        bit          lit;
        sample_t     want;
    } request_t;

    typedef struct {
        logic [31:0] q0;
        logic [31:0] qf;
        logic [31:0] tf;
        logic [31:0] vc;
        logic [31:0] ts;
    } profile_t;

    localparam longint LIM62 = 64'sd1 <<< 62;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic [IDX_W-1:0] sample_index = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [DATA_W-1:0] position, velocity, acceleration;
    logic [1:0] segment;
    logic is_last, speed_error;

    // copy of the block's registers
    logic signed [31:0] cur_q0 = 0, cur_qf = 0, cur_vc = 0;
    logic [30:0] cur_tf = TF_RESET, cur_ts = TS_RESET;

    request_t pending_q[$];
    sample_t  sample_q[$];
    int errors = 0;
    bit gaps_on = 1'b1;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    lspb_trajectory_sample DUT (.*);

    always #10 clk = ~clk;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // truncated a*b >> s on magnitudes, clamped to 2^62
    function automatic longint scale_mul(longint a, longint b, int s);
        logic [63:0] ua, ub;
        logic [127:0] p;
        longint m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        if (p[127:64] != 0) m = LIM62;
        else begin
            p = p >> s;
            m = (p[63:0] > LIM62) ? LIM62 : longint'(p[63:0]);
        end
        return neg ? -m : m;
    endfunction

    function automatic sample_t trajectory_at(logic [15:0] idx);
        longint i, tf, ts, vc, q0, qf, d, vt, b1, b2, lo, hi, tb, acc, t, num, u;
        sample_t r;
        r = '{0, 0, 0, SEG_ACCEL, 1'b0, 1'b0};
        i = idx; tf = cur_tf; ts = cur_ts; vc = cur_vc; q0 = cur_q0; qf = cur_qf;
        d = qf - q0;
        vt = vc * tf;
        b1 = d * 65536;
        b2 = 2 * d * 65536;
        lo = b1 < b2 ? b1 : b2;
        hi = b1 < b2 ? b2 : b1;
        if (tf == 0 || vt < lo || vt > hi) begin
            r.err = 1'b1;
            return r;
        end
        tb = (vc == 0) ? 1 : (vt - b1) / vc;
        if (tb == 0) acc = vc > 0 ? 64'sd2147483647 : -64'sd2147483648;
        else acc = sat32((vc * 65536) / tb);
        t = i * ts;
        if (t <= tb) begin
            r.vel = sat32(scale_mul(acc, t, 16));
            r.pos = sat32(q0 + scale_mul(longint'(r.vel), t, 17));
            r.acc = acc;
            r.seg = SEG_ACCEL;
        end else if (t <= tf - tb) begin
            num = (qf + q0) * 65536 + vc * (2 * t - tf);
            r.pos = sat32(num / 131072);
            r.vel = vc;
            r.seg = SEG_CRUISE;
        end else begin
            u = tf - t;
            r.vel = sat32(scale_mul(acc, u, 16));
            r.pos = sat32(qf - scale_mul(longint'(r.vel), u, 17));
            r.acc = sat32(-acc);
            r.seg = SEG_DECEL;
        end
        r.last = ((i + 1) * ts >= tf);
        return r;
    endfunction

    // record each accepted request
    always @(posedge clk) begin
        request_t rq;
        if (in_valid && in_ready) begin
            rq = pending_q.pop_front();
            sample_q.push_back(rq.lit ? rq.want : trajectory_at(rq.idx));
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        sample_t w;
        if (out_valid && out_ready) begin
            if (sample_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                w = sample_q.pop_front();
                if (position !== w.pos) begin
                    $error("position: expected %0d actual %0d", w.pos, position); errors++;
                end
                if (velocity !== w.vel) begin
                    $error("velocity: expected %0d actual %0d", w.vel, velocity); errors++;
                end
                if (acceleration !== w.acc) begin
                    $error("acceleration: expected %0d actual %0d", w.acc, acceleration);
                    errors++;
                end
                if (segment !== w.seg) begin
                    $error("segment: expected %0d actual %0d", w.seg, segment); errors++;
                end
                if (is_last !== w.last) begin
                    $error("is_last: expected %0d actual %0d", w.last, is_last); errors++;
                end
                if (speed_error !== w.err) begin
                    $error("speed_error: expected %0d actual %0d", w.err, speed_error);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = 80;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 1'b0;
        end else
            out_ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 16);
    end

    task automatic send_request(logic [15:0] idx, bit lit, sample_t want);
        request_t rq;
        if (gaps_on) begin
            while ($urandom_range(99) < 16) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        rq.idx = idx; rq.lit = lit; rq.want = want;
        pending_q.push_back(rq);
        in_valid <= 1'b1;
        sample_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0 || pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_Q0: cur_q0 = v;
            REG_QF: cur_qf = v;
            REG_TF: cur_tf = v[30:0];
            REG_V:  cur_vc = v;
            REG_TS: cur_ts = v[30:0];
            default: ;
        endcase
    endtask

    task automatic load_profile(profile_t p);
        drain();
        write_reg(REG_Q0, p.q0);
        write_reg(REG_QF, p.qf);
        write_reg(REG_TF, p.tf);
        write_reg(REG_V,  p.vc);
        write_reg(REG_TS, p.ts);
    endtask

    localparam sample_t NONE = '{0, 0, 0, SEG_ACCEL, 1'b0, 1'b0};
    localparam sample_t FAULT = '{0, 0, 0, SEG_ACCEL, 1'b0, 1'b1};

    // profile 0 is the reset state and is not written
    profile_t setups [8] = '{
        '{32'd0, 32'd0, 32'd655360, 32'd0, 32'd66},
        '{32'd0, 32'd655360, 32'd655360, 32'd98304, 32'd6554},       // plain rise
        '{32'd0, 32'd655360, 32'd655360, 32'd32768, 32'd6554},       // too slow
        '{32'd655360, -32'sd655360, 32'd655360, -32'sd196608, 32'd6554}, // falling move
        '{32'd0, 32'd655360, 32'd655360, 32'd65536, 32'd6554},       // no blend time
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd6554},                     // zero final time
        '{32'd100, 32'd100, 32'd655360, 32'd0, 32'd0},               // zero period, no move
        '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff}
    };

    typedef struct {
        int          setup;
        logic [15:0] idx;
        bit          lit;
        sample_t     want;
    } row_t;

    row_t script [24] = '{
        '{0, 16'd0, 1, NONE},
        '{0, 16'd1, 1, '{0, 0, 0, SEG_CRUISE, 1'b0, 1'b0}},
        '{0, 16'hffff, 1, '{0, 0, 0, SEG_DECEL, 1'b1, 1'b0}},
        '{1, 16'd0, 0, NONE}, '{1, 16'd50, 0, NONE}, '{1, 16'd99, 0, NONE},
        '{1, 16'd100, 0, NONE},
        '{2, 16'd0, 1, FAULT}, '{2, 16'hffff, 1, FAULT},
        '{3, 16'd0, 0, NONE}, '{3, 16'd40, 0, NONE}, '{3, 16'd97, 0, NONE},
        '{4, 16'd0, 0, NONE}, '{4, 16'd50, 0, NONE}, '{4, 16'd100, 0, NONE},
        '{5, 16'd0, 1, FAULT}, '{5, 16'd7, 1, FAULT},
        '{6, 16'd0, 0, NONE}, '{6, 16'hffff, 0, NONE}, '{6, 16'h5a5a, 0, NONE},
        '{7, 16'd0, 1, FAULT}, '{7, 16'hffff, 1, FAULT},
        '{1, 16'd120, 0, NONE}, '{1, 16'hffff, 0, NONE}
    };

    initial begin
        int cur;
        int steps, span;
        longint delta, tfv, vv;
        profile_t p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cur = 0;
        foreach (script[k]) begin
            if (script[k].setup != cur) begin
                cur = script[k].setup;
                load_profile(setups[cur]);
            end
            send_request(script[k].idx, script[k].lit, script[k].want);
        end

        for (int ph = 0; ph < 14; ph++) begin
            if (ph % 5 == 4) begin
                // arbitrary register contents, mostly infeasible
                p = '{$urandom, $urandom, $urandom, $urandom, $urandom};
            end else begin
                tfv = $urandom_range(4096, 1 << 22);
                delta = $urandom_range(0, 1 << $urandom_range(0, 24));
                if ($urandom_range(1)) delta = -delta;
                p.q0 = $urandom_range(0, 1 << 30) - (1 << 29);
                p.qf = p.q0 + delta;
                vv = (delta * 65536 * (100 + int'($urandom_range(0, 100)))) / (100 * tfv);
                p.tf = tfv;
                p.vc = vv;
                if (ph == 6) p.vc = 0;
                if (ph == 6) p.qf = p.q0;
                span = $urandom_range(8, 200);
                p.ts = (tfv / span == 0) ? 1 : tfv / span;
            end
            load_profile(p);
            span = (cur_ts == 0) ? 100 : cur_tf / cur_ts;
            if (span > 1000) span = 1000;
            gaps_on = (ph != 2 && ph != 8);
            rx_quiet = (ph == 8);
            if (ph == 2) hold_req = 1'b1;
            for (steps = 0; steps < 52; steps++) begin
                if (ph == 5 && steps == 20) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sample_q.size() != 0) @(posedge clk);
                end
                if ($urandom_range(9) == 0)
                    send_request($urandom, 0, NONE);
                else
                    send_request($urandom_range(0, span + 2), 0, NONE);
            end
        end
        drain();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #40000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
